// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, synchronous active-low reset disables them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ecat_pkg.sv =====
package ecat_pkg;

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_DST     = 4'd1;
    localparam logic [3:0] PH_SRC     = 4'd2;
    localparam logic [3:0] PH_TYPE    = 4'd3;
    localparam logic [3:0] PH_ECHDR   = 4'd4;
    localparam logic [3:0] PH_DHDR    = 4'd5;
    localparam logic [3:0] PH_DIRQ    = 4'd6;
    localparam logic [3:0] PH_PAYLOAD = 4'd7;
    localparam logic [3:0] PH_WKC     = 4'd8;

    localparam logic [1:0] KIND_HDR   = 2'd0;
    localparam logic [1:0] KIND_DGRAM = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    localparam logic [10:0] MAC_BYTES   = 11'd6;
    localparam logic [10:0] WORD_BYTES  = 11'd2;
    localparam logic [10:0] DHDR_BYTES  = 11'd8;
    localparam logic [15:0] ECAT_ETYPE  = 16'h88A4;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [15:0] ethertype;
        logic [10:0] frame_length;
        logic [3:0]  frame_type;
        logic [7:0]  command;
        logic [7:0]  dgram_index;
        logic [31:0] dgram_address;
        logic [10:0] dgram_length;
        logic [1:0]  dgram_flags;
        logic [31:0] irq_and_wkc;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_res;

endpackage

// ===== rtl/ecat_parse.sv =====
module ecat_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [7:0]        i_data_byte,
    input  logic              i_frame_start,
    input  logic              i_hold,
    output logic              o_busy,
    output ecat_pkg::t_res    o_res
);

    logic        r_in_valid;
    logic [7:0]  r_data;
    logic        r_start;

    logic [3:0]  r_phase,  n_phase;
    logic [10:0] r_count,  n_count;
    logic [47:0] r_dst,    n_dst;
    logic [47:0] r_src,    n_src;
    logic [15:0] r_type,   n_type;
    logic [15:0] r_hdr,    n_hdr;
    logic [63:0] r_dg,     n_dg;
    logic [15:0] r_irq,    n_irq;
    logic [15:0] r_wkc,    n_wkc;

    logic        process;
    logic [3:0]  cur_phase;
    logic [10:0] cnt1;
    logic [15:0] dword;
    ecat_pkg::t_res res;

    assign process = r_in_valid & ~i_hold;
    assign o_busy  = r_in_valid;
    assign o_res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_load) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data  <= i_data_byte;
            r_start <= i_frame_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ecat_pkg::PH_IDLE;
            r_count <= '0;
        end else if (process) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_dst <= n_dst;
            r_src <= n_src;
            r_type <= n_type;
            r_hdr <= n_hdr;
            r_dg  <= n_dg;
            r_irq <= n_irq;
            r_wkc <= n_wkc;
        end
    end

    always_comb begin
        cur_phase = r_start ? ecat_pkg::PH_DST : r_phase;
        n_count   = r_start ? 11'd0 : r_count;
        n_dst     = r_start ? 48'd0 : r_dst;
        n_src     = r_start ? 48'd0 : r_src;
        n_type    = r_start ? 16'd0 : r_type;
        n_hdr     = r_start ? 16'd0 : r_hdr;
        n_dg      = r_start ? 64'd0 : r_dg;
        n_irq     = r_start ? 16'd0 : r_irq;
        n_wkc     = r_start ? 16'd0 : r_wkc;
        n_phase   = cur_phase;
        cnt1      = n_count + 11'd1;
        dword     = n_dg[63:48];
        res       = '0;

        case (cur_phase)
            ecat_pkg::PH_DST: begin
                n_dst   = {n_dst[39:0], r_data};
                n_count = cnt1;
                if (cnt1 == ecat_pkg::MAC_BYTES) begin
                    n_count = '0;
                    n_phase = ecat_pkg::PH_SRC;
                end
            end
            ecat_pkg::PH_SRC: begin
                n_src   = {n_src[39:0], r_data};
                n_count = cnt1;
                if (cnt1 == ecat_pkg::MAC_BYTES) begin
                    n_count = '0;
                    n_phase = ecat_pkg::PH_TYPE;
                end
            end
            ecat_pkg::PH_TYPE: begin
                n_type  = {n_type[7:0], r_data};
                n_count = cnt1;
                if (cnt1 == ecat_pkg::WORD_BYTES) begin
                    n_count = '0;
                    if (n_type != ecat_pkg::ECAT_ETYPE) begin
                        res.valid           = 1'b1;
                        res.rec.record_kind = ecat_pkg::KIND_ERR;
                        n_phase             = ecat_pkg::PH_IDLE;
                    end else begin
                        n_phase = ecat_pkg::PH_ECHDR;
                    end
                end
            end
            ecat_pkg::PH_ECHDR: begin
                n_hdr   = {r_data, n_hdr[15:8]};
                n_count = cnt1;
                if (cnt1 == ecat_pkg::WORD_BYTES) begin
                    n_count                = '0;
                    res.valid              = 1'b1;
                    res.rec.record_kind    = ecat_pkg::KIND_HDR;
                    n_phase                = ecat_pkg::PH_DHDR;
                end
            end
            ecat_pkg::PH_DHDR: begin
                n_dg    = {r_data, n_dg[63:8]};
                n_count = cnt1;
                if (cnt1 == ecat_pkg::DHDR_BYTES) begin
                    n_count = '0;
                    n_phase = ecat_pkg::PH_DIRQ;
                end
            end
            ecat_pkg::PH_DIRQ: begin
                n_irq   = {r_data, n_irq[15:8]};
                n_count = cnt1;
                if (cnt1 == ecat_pkg::WORD_BYTES) begin
                    n_count = '0;
                    n_phase = (dword[10:0] == 11'd0) ? ecat_pkg::PH_WKC
                                                     : ecat_pkg::PH_PAYLOAD;
                end
            end
            ecat_pkg::PH_PAYLOAD: begin
                n_count = cnt1;
                if (cnt1 == dword[10:0]) begin
                    n_count = '0;
                    n_phase = ecat_pkg::PH_WKC;
                end
            end
            ecat_pkg::PH_WKC: begin
                n_wkc   = {r_data, n_wkc[15:8]};
                n_count = cnt1;
                if (cnt1 == ecat_pkg::WORD_BYTES) begin
                    n_count               = '0;
                    res.valid             = 1'b1;
                    res.rec.record_kind   = ecat_pkg::KIND_DGRAM;
                    res.rec.command       = n_dg[7:0];
                    res.rec.dgram_index   = n_dg[15:8];
                    res.rec.dgram_address = n_dg[47:16];
                    res.rec.dgram_length  = dword[10:0];
                    res.rec.dgram_flags   = {dword[15], dword[13]};
                    res.rec.irq_and_wkc   = {n_wkc, n_irq};
                    n_phase = dword[15] ? ecat_pkg::PH_DHDR : ecat_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = ecat_pkg::PH_IDLE;
            end
        endcase

        res.valid           = res.valid & process;
        res.rec.dst_mac     = n_dst;
        res.rec.src_mac     = n_src;
        res.rec.ethertype   = n_type;
        if (res.rec.record_kind != ecat_pkg::KIND_ERR) begin
            res.rec.frame_length = n_hdr[10:0];
            res.rec.frame_type   = n_hdr[15:12];
        end
    end

endmodule

// ===== rtl/ecat_out.sv =====
module ecat_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecat_pkg::t_res    i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_full,
    output ecat_pkg::t_rec    o_rec
);

    logic           r_main_valid;
    logic           r_skid_valid;
    ecat_pkg::t_rec r_main;
    ecat_pkg::t_rec r_skid;
    logic           pop;

    assign pop     = r_main_valid & ~i_stall;
    assign o_valid = r_main_valid;
    assign o_full  = r_skid_valid;
    assign o_rec   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            r_main_valid <= r_skid_valid | i_res.valid;
            r_skid_valid <= 1'b0;
        end else if (i_res.valid) begin
            r_main_valid <= 1'b1;
            r_skid_valid <= r_main_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : i_res.rec;
        end else if (i_res.valid) begin
            if (r_main_valid) begin
                r_skid <= i_res.rec;
            end else begin
                r_main <= i_res.rec;
            end
        end
    end

endmodule

// ===== rtl/ethercat_frame_parser.sv =====
// A byte is registered at the input, then its record in the result register or skid.
// Throughput: one byte per cycle while o_stall is low; at most one record per byte.
// Two output slots (result register plus skid) decouple the input from output stalls.
// Synchronous active-low reset returns the parser to idle and empties all stages.
module ethercat_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_record_kind,
    output logic [47:0] o_dst_mac,
    output logic [47:0] o_src_mac,
    output logic [15:0] o_ethertype,
    output logic [10:0] o_frame_length,
    output logic [3:0]  o_frame_type,
    output logic [7:0]  o_command,
    output logic [7:0]  o_dgram_index,
    output logic [31:0] o_dgram_address,
    output logic [10:0] o_dgram_length,
    output logic [1:0]  o_dgram_flags,
    output logic [31:0] o_irq_and_wkc
);

    logic           busy;
    logic           full;
    ecat_pkg::t_res res;
    ecat_pkg::t_rec rec;

    assign o_stall = busy & full;

    ecat_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (i_valid & ~o_stall),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .i_hold        (full),
        .o_busy        (busy),
        .o_res         (res)
    );

    ecat_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_full  (full),
        .o_rec   (rec)
    );

    assign o_record_kind   = rec.record_kind;
    assign o_dst_mac       = rec.dst_mac;
    assign o_src_mac       = rec.src_mac;
    assign o_ethertype     = rec.ethertype;
    assign o_frame_length  = rec.frame_length;
    assign o_frame_type    = rec.frame_type;
    assign o_command       = rec.command;
    assign o_dgram_index   = rec.dgram_index;
    assign o_dgram_address = rec.dgram_address;
    assign o_dgram_length  = rec.dgram_length;
    assign o_dgram_flags   = rec.dgram_flags;
    assign o_irq_and_wkc   = rec.irq_and_wkc;

endmodule

// ===== rtl/ecat_checker.sv =====
`include "assert_macros.svh"

module ecat_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_stall,
    input  logic        o_valid,
    input  logic        i_stall,
    input  logic [1:0]  o_record_kind,
    input  logic [15:0] o_ethertype,
    input  logic [10:0] o_frame_length,
    input  logic [3:0]  o_frame_type,
    input  logic [7:0]  o_command,
    input  logic [10:0] o_dgram_length,
    input  logic [31:0] o_irq_and_wkc
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_record_kind))
    `ASSERT_IMPL(a_err_no_hdr, i_clk, i_rst_n, o_valid && o_record_kind == ecat_pkg::KIND_ERR,
        o_frame_length == 11'd0 && o_frame_type == 4'd0 && o_ethertype != ecat_pkg::ECAT_ETYPE)
    `ASSERT_IMPL(a_hdr_no_dgram, i_clk, i_rst_n, o_valid && o_record_kind == ecat_pkg::KIND_HDR,
        o_command == 8'd0 && o_dgram_length == 11'd0 && o_irq_and_wkc == 32'd0)
    `ASSERT_IMPL(a_ecat_type, i_clk, i_rst_n, o_valid && o_record_kind != ecat_pkg::KIND_ERR,
        o_ethertype == ecat_pkg::ECAT_ETYPE)
    `ASSERT_NEXT(a_stall_needs_out, i_clk, i_rst_n, o_stall, o_valid)

endmodule

bind ethercat_frame_parser ecat_checker u_ecat_checker (.*);
